>>> sv/lbvs_pkg.sv
// Package for the four-joint linear blend vertex skinning block.
// Holds the sizing constants, command codes and request/response structs.
// No dependencies.
`default_nettype none

package lbvs_pkg;

  // Number of joint matrices held in the table.
  localparam int JOINT_COUNT     = 64;
  // Fractional bits of matrix elements and vector components.
  localparam int COORD_FRAC_BITS = 16;
  // Fractional bits of the blend weights (Q1.15).
  localparam int WEIGHT_FRAC     = 15;

  // Joint table address width.
  localparam int JA_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

  // Command codes.
  localparam logic [1:0] CMD_LOAD     = 2'd0;
  localparam logic [1:0] CMD_POSITION = 2'd1;
  localparam logic [1:0] CMD_NORMAL   = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         joint_a;
    logic [5:0]         joint_b;
    logic [5:0]         joint_c;
    logic [5:0]         joint_d;
    logic [15:0]        weight_a;
    logic [15:0]        weight_b;
    logic [15:0]        weight_c;
    logic [15:0]        weight_d;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_rsp_t;

endpackage

`default_nettype wire

>>> sv/linear_blend_vertex_skinning.sv
// Top level of the four-joint linear blend vertex skinning block.
// Depends on lbvs_pkg for constants, command codes and the payload structs.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_req  (in_req_t)
//   out     | output    | out_valid / out_ready| out_rsp (out_rsp_t)
//
// A skin request passes five register stages: table read, weight multiply,
// blend sum, vector multiply, row sum. Its result is valid once it reaches
// the row-sum register. One request enters per cycle unless an output stall
// has filled every stage; the 64 table banks and the 64 weight and 12 vector
// multipliers set that rate. Loads write the table at acceptance and leave no
// result. Each stage moves when it is empty or the next one moves, so bubbles
// close up during an output stall. Reset clears the valid bits only; the
// joint table holds no defined value until written.
`default_nettype none

module linear_blend_vertex_skinning
  import lbvs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_rsp_t      out_rsp
);

  localparam int F  = COORD_FRAC_BITS;
  localparam int PW = 64 - F;   // width of a shifted row product
  localparam int SW = PW + 2;   // width of a row sum

  // Stage valid bits and the ready chain.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  logic accept;
  assign accept = in_valid && rdy1;

  // Decode the request.
  logic [5:0]  joint_in  [4];
  logic [15:0] weight_in [4];
  logic        skin_in;
  logic        load_ok;

  always_comb begin
    joint_in[0]  = in_req.joint_a;
    joint_in[1]  = in_req.joint_b;
    joint_in[2]  = in_req.joint_c;
    joint_in[3]  = in_req.joint_d;
    weight_in[0] = in_req.weight_a;
    weight_in[1] = in_req.weight_b;
    weight_in[2] = in_req.weight_c;
    weight_in[3] = in_req.weight_d;
    skin_in = (in_req.cmd == CMD_POSITION) || (in_req.cmd == CMD_NORMAL);
    load_ok = (in_req.cmd == CMD_LOAD) && (in_req.vec_y[31:4] == 28'd0) &&
              (int'(in_req.joint_a) < JOINT_COUNT);
  end

  // Stage 1: joint table, one bank per joint slot and element.
  logic signed [31:0] m1_r [4][16];
  logic               jv1_r [4];
  logic [15:0]        w1_r  [4];
  logic signed [31:0] vx1_r, vy1_r, vz1_r;
  logic               pos1_r;

  for (genvar k = 0; k < 4; k++) begin : g_slot
    for (genvar e = 0; e < 16; e++) begin : g_elem
      logic signed [31:0] mem [JOINT_COUNT];

      always_ff @(posedge clk) begin
        if (accept && load_ok && (in_req.vec_y[3:0] == 4'(e))) begin
          mem[JA_W'(in_req.joint_a)] <= in_req.vec_x;
        end
        if (accept) begin
          m1_r[k][e] <= mem[JA_W'(joint_in[k])];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid && skin_in;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        jv1_r[k] <= int'(joint_in[k]) < JOINT_COUNT;
        w1_r[k]  <= weight_in[k];
      end
      vx1_r  <= in_req.vec_x;
      vy1_r  <= in_req.vec_y;
      vz1_r  <= in_req.vec_z;
      pos1_r <= in_req.cmd == CMD_POSITION;
    end
  end

  // Stage 2: weight times element, floor shift by the weight fraction.
  logic signed [32:0] t2_r [4][16];
  logic signed [31:0] vx2_r, vy2_r, vz2_r;
  logic               pos2_r;
  logic signed [48:0] wp [4][16];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int e = 0; e < 16; e++) begin
        wp[k][e] = $signed({1'b0, w1_r[k]}) * m1_r[k][e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int k = 0; k < 4; k++) begin
        for (int e = 0; e < 16; e++) begin
          t2_r[k][e] <= jv1_r[k] ? wp[k][e][47:WEIGHT_FRAC] : 33'sd0;
        end
      end
      vx2_r  <= vx1_r;
      vy2_r  <= vy1_r;
      vz2_r  <= vz1_r;
      pos2_r <= pos1_r;
    end
  end

  // Stage 3: sum the four weighted terms and saturate each element.
  logic signed [31:0] b3_r [16];
  logic signed [31:0] vx3_r, vy3_r, vz3_r;
  logic               pos3_r;
  logic signed [34:0] bsum [16];
  logic signed [31:0] bsat [16];

  always_comb begin
    for (int e = 0; e < 16; e++) begin
      bsum[e] = 35'(t2_r[0][e]) + 35'(t2_r[1][e]) + 35'(t2_r[2][e]) +
                35'(t2_r[3][e]);
      if (bsum[e] > 35'sh07FFFFFFF) begin
        bsat[e] = 32'sh7FFFFFFF;
      end else if (bsum[e] < -35'sh080000000) begin
        bsat[e] = 32'sh80000000;
      end else begin
        bsat[e] = bsum[e][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      b3_r   <= bsat;
      vx3_r  <= vx2_r;
      vy3_r  <= vy2_r;
      vz3_r  <= vz2_r;
      pos3_r <= pos2_r;
    end
  end

  // Stage 4: matrix column times vector component, floor shift.
  logic signed [PW-1:0] p4_r [4][3];
  logic signed [31:0]   tr4_r [4];
  logic                 pos4_r;
  logic signed [63:0]   vp [4][3];
  logic signed [31:0]   vsel [3];

  always_comb begin
    vsel[0] = vx3_r;
    vsel[1] = vy3_r;
    vsel[2] = vz3_r;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        vp[r][c] = b3_r[c*4 + r] * vsel[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          p4_r[r][c] <= vp[r][c][63:F];
        end
        tr4_r[r] <= b3_r[12 + r];
      end
      pos4_r <= pos3_r;
    end
  end

  // Stage 5: row sums with translation for positions, then saturate.
  logic signed [SW-1:0] rsum [4];
  logic signed [31:0]   rsat [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rsum[r] = SW'(p4_r[r][0]) + SW'(p4_r[r][1]) + SW'(p4_r[r][2]) +
                (pos4_r ? SW'(tr4_r[r]) : SW'(0));
      if (rsum[r] > SW'(64'sh7FFFFFFF)) begin
        rsat[r] = 32'sh7FFFFFFF;
      end else if (rsum[r] < SW'(-64'sh80000000)) begin
        rsat[r] = 32'sh80000000;
      end else begin
        rsat[r] = rsum[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      out_rsp.out_x <= rsat[0];
      out_rsp.out_y <= rsat[1];
      out_rsp.out_z <= rsat[2];
      out_rsp.out_w <= pos4_r ? rsat[3] : 32'sd0;
    end
  end

  assign out_valid = v5_r;

endmodule

`default_nettype wire

>>> dv/lbvs_checker.sv
// Checker for the four-joint linear blend vertex skinning block.
// Watches both channels, keeps its own joint table, predicts each result and compares.
// Depends on lbvs_pkg for the request/response structs and command codes.
`timescale 1ns / 100ps

module lbvs_checker
  import lbvs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_rsp_t out_rsp,
  output int       fail_count,
  output int       pending
);

  // Shadow of the joint table, indexed joint*16 + element.
  int       joint_store [JOINT_COUNT*16];
  out_rsp_t vertex_q [$];
  int       report_count;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Blend four joint matrices by their weights, then transform the vector.
  function automatic out_rsp_t skin_vertex(in_req_t r);
    longint   blend [16];
    longint   vec [3];
    longint   acc;
    int       jnt [4];
    longint   wgt [4];
    longint   row_val [4];
    out_rsp_t rsp;
    jnt[0] = int'(r.joint_a); jnt[1] = int'(r.joint_b);
    jnt[2] = int'(r.joint_c); jnt[3] = int'(r.joint_d);
    wgt[0] = longint'({48'd0, r.weight_a});
    wgt[1] = longint'({48'd0, r.weight_b});
    wgt[2] = longint'({48'd0, r.weight_c});
    wgt[3] = longint'({48'd0, r.weight_d});
    vec[0] = longint'(r.vec_x);
    vec[1] = longint'(r.vec_y);
    vec[2] = longint'(r.vec_z);
    for (int e = 0; e < 16; e++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) begin
        if (jnt[k] < JOINT_COUNT)
          acc += (wgt[k] * longint'(joint_store[jnt[k]*16 + e])) >>> WEIGHT_FRAC;
      end
      blend[e] = clamp32(acc);
    end
    for (int rw = 0; rw < 4; rw++) begin
      acc = 0;
      for (int c = 0; c < 3; c++)
        acc += (blend[c*4 + rw] * vec[c]) >>> COORD_FRAC_BITS;
      // Positions carry an implicit w of one, so translation adds unscaled.
      if (r.cmd == CMD_POSITION)
        acc += blend[12 + rw];
      row_val[rw] = clamp32(acc);
    end
    if (r.cmd == CMD_NORMAL)
      row_val[3] = 0;
    rsp.out_x = row_val[0][31:0];
    rsp.out_y = row_val[1][31:0];
    rsp.out_z = row_val[2][31:0];
    rsp.out_w = row_val[3][31:0];
    return rsp;
  endfunction

  // Track requests and compare each result with the oldest prediction.
  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    if (!rst_n) begin
      vertex_q.delete();
      fail_count   <= 0;
      report_count = 0;
      pending      <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_req.cmd == CMD_LOAD) begin
          if (in_req.vec_y >= 0 && in_req.vec_y <= 15 && in_req.joint_a < JOINT_COUNT)
            joint_store[in_req.joint_a*16 + in_req.vec_y] = in_req.vec_x;
        end else if (in_req.cmd == CMD_POSITION || in_req.cmd == CMD_NORMAL) begin
          vertex_q.push_back(skin_vertex(in_req));
        end
      end
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (report_count < 10)
            $display("ERROR: unexpected result %h", out_rsp);
          report_count++;
        end else begin
          exp_rsp = vertex_q.pop_front();
          if (out_rsp !== exp_rsp) begin
            fail_count <= fail_count + 1;
            if (report_count < 10)
              $display("ERROR: result expected x=%h y=%h z=%h w=%h got x=%h y=%h z=%h w=%h",
                       exp_rsp.out_x, exp_rsp.out_y, exp_rsp.out_z, exp_rsp.out_w,
                       out_rsp.out_x, out_rsp.out_y, out_rsp.out_z, out_rsp.out_w);
            report_count++;
          end
        end
      end
      pending <= vertex_q.size();
    end
  end

endmodule

>>> dv/linear_blend_vertex_skinning_tb.sv
// Testbench top for the four-joint linear blend vertex skinning block.
// Drives requests and result back-pressure, gives the verdict; checking is in lbvs_checker.
// Depends on lbvs_pkg, linear_blend_vertex_skinning and lbvs_checker.
`timescale 1ns / 100ps

module linear_blend_vertex_skinning_tb;
  import lbvs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TOTAL = 1150;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int REQ_W = $bits(in_req_t);

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_rsp;
  int       fail_count;
  int       pending;

  // Joints whose matrix is complete.
  int       full_joints [$];
  int       item_count;
  bit       send_burst;
  bit       recv_burst;
  bit       long_hold;
  int       idle_cycles;

  linear_blend_vertex_skinning u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
  );

  lbvs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(in_req_t r);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    item_count++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 262143)) - 131072);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 8388607)) - 4194304);
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'd32768;
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic load_elem(int jnt, int idx, logic [31:0] val);
    in_req_t r;
    r = in_req_t'(REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom()}));
    r.cmd = CMD_LOAD; r.joint_a = 6'(jnt); r.vec_x = val; r.vec_y = idx;
    send_request(r);
  endtask

  task automatic load_joint(int jnt);
    for (int e = 0; e < 16; e++)
      load_elem(jnt, e, rand_value());
    if (!(jnt inside {full_joints}))
      full_joints.push_back(jnt);
  endtask

  task automatic skin_request(logic [1:0] cmd, int ja, int jb, int jc, int jd,
                              logic [15:0] wa, logic [15:0] wb, logic [15:0] wc,
                              logic [15:0] wd, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z);
    in_req_t r;
    r.cmd = cmd;
    r.joint_a = 6'(ja); r.joint_b = 6'(jb); r.joint_c = 6'(jc); r.joint_d = 6'(jd);
    r.weight_a = wa; r.weight_b = wb; r.weight_c = wc; r.weight_d = wd;
    r.vec_x = x; r.vec_y = y; r.vec_z = z;
    send_request(r);
  endtask

  function automatic int pick_joint();
    return full_joints[$urandom_range(0, full_joints.size() - 1)];
  endfunction

  task automatic random_skin();
    skin_request($urandom_range(0, 1) ? CMD_POSITION : CMD_NORMAL,
                 pick_joint(), pick_joint(), pick_joint(), pick_joint(),
                 rand_weight(), rand_weight(), rand_weight(), rand_weight(),
                 rand_value(), rand_value(), rand_value());
  endtask

  // Result side: random stalls, fast stretches, and one long hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !long_hold);
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any accepted request or result.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Stimulus: table setup, directed cases, then mostly well-formed random traffic.
  initial begin
    int choice;
    int jnt;
    in_req_t noise;
    bit hold_done;
    bit drain_done;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    long_hold  = 1'b0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    item_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Joint 0 is identity; joint 63 holds the extreme element values.
    for (int e = 0; e < 16; e++)
      load_elem(0, e, (e % 5 == 0) ? 32'h00010000 : 32'h0);
    full_joints.push_back(0);
    for (int e = 0; e < 16; e++)
      load_elem(63, e, e[0] ? 32'h80000000 : 32'h7fffffff);
    full_joints.push_back(63);
    load_joint(21);
    load_joint(42);

    skin_request(CMD_POSITION, 0, 0, 0, 0, 16'd32768, 0, 0, 0,
                 32'h7fffffff, 32'h80000000, 32'h00010000);
    skin_request(CMD_NORMAL, 0, 0, 0, 0, 16'd32768, 0, 0, 0,
                 32'h7fffffff, 32'h80000000, 32'hffffffff);
    // Oversized weights saturate the blended matrix.
    skin_request(CMD_POSITION, 63, 63, 63, 63, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    skin_request(CMD_NORMAL, 63, 21, 42, 0, 16'hffff, 16'd32768, 16'd1, 16'd0,
                 32'h80000000, 32'h80000000, 32'h80000000);
    skin_request(CMD_POSITION, 21, 42, 0, 63, 0, 0, 0, 0,
                 32'hffffffff, 32'h1, 32'h0);
    skin_request(CMD_POSITION, 21, 42, 21, 42, 16'd8192, 16'd8192, 16'd8192, 16'd8192,
                 32'h00020000, 32'hfffe0000, 32'h00008000);
    // Unused command and out-of-range element indexes change nothing.
    skin_request(CMD_UNUSED, 0, 63, 21, 42, 16'hffff, 0, 16'hffff, 0,
                 32'h12345678, 32'h0, 32'h0);
    skin_request(CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'd16, 0);
    skin_request(CMD_LOAD, 63, 0, 0, 0, 0, 0, 0, 0, 32'h0, 32'hffffffff, 0);
    skin_request(CMD_LOAD, 21, 0, 0, 0, 0, 0, 0, 0, 32'h0, 32'h80000000, 0);
    skin_request(CMD_POSITION, 0, 63, 0, 63, 16'd32768, 0, 0, 0,
                 32'h00030000, 32'h00040000, 32'h00050000);

    while (item_count < ITEM_TOTAL) begin
      if ($urandom_range(0, 50) == 0) send_burst = ~send_burst;
      if (!hold_done && item_count >= 450) begin
        hold_done  = 1'b1;
        long_hold  = 1'b1;
        send_burst = 1'b1;
      end
      // Pause until the pipeline has drained.
      if (!drain_done && item_count >= 800) begin
        drain_done = 1'b1;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
      end
      choice = $urandom_range(0, 99);
      if (choice < 8) begin
        jnt = $urandom_range(0, 63);
        load_joint(jnt);
      end else if (choice < 16) begin
        load_elem(pick_joint(), $urandom_range(0, 15), rand_value());
      end else if (choice < 20) begin
        noise = in_req_t'(REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom(), $urandom()}));
        if (noise.cmd == CMD_LOAD) begin
          if (noise.vec_y >= 0 && noise.vec_y <= 15) noise.vec_y = 32'd16 + noise.vec_y[7:0];
        end else noise.cmd = CMD_UNUSED;
        send_request(noise);
      end else begin
        random_skin();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
